// ===== rtl/gsp_pkg.sv =====
// Package for the geometry string parser: character codes, parse phase
// encoding, accumulator width and the value formatting helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gsp_pkg;

  localparam int VALUE_BITS = 16;
  localparam int EXT_BITS   = (VALUE_BITS > 17) ? VALUE_BITS : 17;
  localparam int SUM_BITS   = VALUE_BITS + 4;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [8:0] {
    PH_START  = 9'b000000001,
    PH_WBEGIN = 9'b000000010,
    PH_WNUM   = 9'b000000100,
    PH_HBEGIN = 9'b000001000,
    PH_HNUM   = 9'b000010000,
    PH_XBEGIN = 9'b000100000,
    PH_XNUM   = 9'b001000000,
    PH_YBEGIN = 9'b010000000,
    PH_YNUM   = 9'b100000000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  found;
    logic [1:0]  neg;
    logic [2:0]  inner;
    logic        err;
  } parse_state_t;

  function automatic logic [16:0] signed_field(input logic [VALUE_BITS-1:0] mag,
                                               input logic neg);
    logic [EXT_BITS-1:0] m;
    logic [EXT_BITS-1:0] r;
    begin
      m = EXT_BITS'(mag);
      r = neg ? (~m + EXT_BITS'(1)) : m;
      signed_field = r[16:0];
    end
  endfunction

  function automatic logic [15:0] unsigned_field(input logic [VALUE_BITS-1:0] mag);
    logic [EXT_BITS-1:0] m;
    begin
      m = EXT_BITS'(mag);
      unsigned_field = m[15:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gsp_accum.sv =====
// Decimal digit step: multiplies an accumulator by ten, adds one digit and
// saturates at the largest magnitude. Depends on gsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsp_accum (
  input  wire logic [gsp_pkg::VALUE_BITS-1:0] acc_in,
  input  wire logic [3:0]                     digit,
  output logic      [gsp_pkg::VALUE_BITS-1:0] acc_out
);

  logic [gsp_pkg::SUM_BITS-1:0] ext;
  logic [gsp_pkg::SUM_BITS-1:0] sum;

  always_comb begin
    ext = gsp_pkg::SUM_BITS'(acc_in);
    sum = (ext << 3) + (ext << 1) + gsp_pkg::SUM_BITS'(digit);
    if (sum > gsp_pkg::SUM_BITS'(gsp_pkg::VALUE_MAX)) begin
      acc_out = gsp_pkg::VALUE_MAX;
    end else begin
      acc_out = sum[gsp_pkg::VALUE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gsp_parser.sv =====
// Parse phase, flags and the four decimal accumulators, stepped once per
// character. Depends on gsp_pkg and gsp_accum.
`timescale 1ns / 1ps
`default_nettype none
module gsp_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [7:0]                     ch,
  output gsp_pkg::parse_state_t               st,
  output logic      [gsp_pkg::VALUE_BITS-1:0] w_acc,
  output logic      [gsp_pkg::VALUE_BITS-1:0] h_acc,
  output logic      [gsp_pkg::VALUE_BITS-1:0] x_acc,
  output logic      [gsp_pkg::VALUE_BITS-1:0] y_acc
);

  gsp_pkg::parse_state_t             st_r, st_nxt;
  logic [gsp_pkg::VALUE_BITS-1:0]    w_r, h_r, x_r, y_r;
  logic [gsp_pkg::VALUE_BITS-1:0]    w_nxt, h_nxt, x_nxt, y_nxt;
  logic [gsp_pkg::VALUE_BITS-1:0]    acc_in, acc_out;
  logic [1:0]                        acc_sel;
  logic                              acc_we;
  gsp_pkg::phase_t                   ph;
  logic                              is_digit, is_sign, is_minus;

  gsp_accum u_accum (
    .acc_in  (acc_in),
    .digit   (ch[3:0]),
    .acc_out (acc_out)
  );

  always_comb begin
    is_digit = (ch >= gsp_pkg::CH_ZERO) && (ch <= gsp_pkg::CH_NINE);
    is_minus = (ch == gsp_pkg::CH_MINUS);
    is_sign  = (ch == gsp_pkg::CH_PLUS) || is_minus;
    ph       = (st_r.phase == gsp_pkg::PH_START) ? gsp_pkg::PH_WBEGIN : st_r.phase;
    case (ph)
      gsp_pkg::PH_HBEGIN, gsp_pkg::PH_HNUM: acc_sel = 2'd1;
      gsp_pkg::PH_XBEGIN, gsp_pkg::PH_XNUM: acc_sel = 2'd2;
      gsp_pkg::PH_YBEGIN, gsp_pkg::PH_YNUM: acc_sel = 2'd3;
      default:                              acc_sel = 2'd0;
    endcase
    case (acc_sel)
      2'd1:    acc_in = h_r;
      2'd2:    acc_in = x_r;
      2'd3:    acc_in = y_r;
      default: acc_in = w_r;
    endcase

    st_nxt = st_r;
    acc_we = 1'b0;
    w_nxt  = w_r;
    h_nxt  = h_r;
    x_nxt  = x_r;
    y_nxt  = y_r;

    if (ch == gsp_pkg::CH_NUL) begin
      st_nxt = '{phase: gsp_pkg::PH_START, found: '0, neg: '0, inner: '0, err: 1'b0};
      w_nxt  = '0;
      h_nxt  = '0;
      x_nxt  = '0;
      y_nxt  = '0;
    end else if (!st_r.err) begin
      st_nxt.phase = ph;
      if (!(st_r.phase == gsp_pkg::PH_START && ch == gsp_pkg::CH_EQ)) begin
        case (ph)
          gsp_pkg::PH_WBEGIN, gsp_pkg::PH_WNUM: begin
            if (is_digit) begin
              acc_we          = 1'b1;
              st_nxt.found[0] = 1'b1;
              st_nxt.phase    = gsp_pkg::PH_WNUM;
            end else if (is_sign) begin
              st_nxt.neg[0] = st_r.neg[0] | is_minus;
              st_nxt.phase  = gsp_pkg::PH_XBEGIN;
            end else if (ch == gsp_pkg::CH_LX ||
                         (ch == gsp_pkg::CH_UX && ph == gsp_pkg::PH_WNUM)) begin
              st_nxt.phase = gsp_pkg::PH_HBEGIN;
            end else begin
              st_nxt.err = 1'b1;
            end
          end
          gsp_pkg::PH_HBEGIN: begin
            if (is_sign || is_digit) begin
              acc_we          = is_digit;
              st_nxt.inner[0] = st_r.inner[0] | is_minus;
              st_nxt.found[1] = 1'b1;
              st_nxt.phase    = gsp_pkg::PH_HNUM;
            end else begin
              st_nxt.err = 1'b1;
            end
          end
          gsp_pkg::PH_XBEGIN: begin
            if (is_sign || is_digit) begin
              acc_we          = is_digit;
              st_nxt.inner[1] = st_r.inner[1] | is_minus;
              st_nxt.found[2] = 1'b1;
              st_nxt.phase    = gsp_pkg::PH_XNUM;
            end else begin
              st_nxt.err = 1'b1;
            end
          end
          gsp_pkg::PH_YBEGIN: begin
            if (is_sign || is_digit) begin
              acc_we          = is_digit;
              st_nxt.inner[2] = st_r.inner[2] | is_minus;
              st_nxt.found[3] = 1'b1;
              st_nxt.phase    = gsp_pkg::PH_YNUM;
            end else begin
              st_nxt.err = 1'b1;
            end
          end
          gsp_pkg::PH_HNUM: begin
            if (is_digit) begin
              acc_we = 1'b1;
            end else if (is_sign) begin
              st_nxt.neg[0] = st_r.neg[0] | is_minus;
              st_nxt.phase  = gsp_pkg::PH_XBEGIN;
            end else begin
              st_nxt.err = 1'b1;
            end
          end
          gsp_pkg::PH_XNUM: begin
            if (is_digit) begin
              acc_we = 1'b1;
            end else if (is_sign) begin
              st_nxt.neg[1] = st_r.neg[1] | is_minus;
              st_nxt.phase  = gsp_pkg::PH_YBEGIN;
            end else begin
              st_nxt.err = 1'b1;
            end
          end
          gsp_pkg::PH_YNUM: begin
            if (is_digit) begin
              acc_we = 1'b1;
            end else begin
              st_nxt.err = 1'b1;
            end
          end
          default: begin
            st_nxt.err = 1'b1;
          end
        endcase
      end
      if (acc_we) begin
        case (acc_sel)
          2'd1:    h_nxt = acc_out;
          2'd2:    x_nxt = acc_out;
          2'd3:    y_nxt = acc_out;
          default: w_nxt = acc_out;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: gsp_pkg::PH_START, found: '0, neg: '0, inner: '0, err: 1'b0};
      w_r  <= '0;
      h_r  <= '0;
      x_r  <= '0;
      y_r  <= '0;
    end else if (step) begin
      st_r <= st_nxt;
      w_r  <= w_nxt;
      h_r  <= h_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
    end
  end

  assign st    = st_r;
  assign w_acc = w_r;
  assign h_acc = h_r;
  assign x_acc = x_r;
  assign y_acc = y_r;

endmodule
`default_nettype wire

// ===== rtl/gsp_format.sv =====
// Result register: turns the parser state at the end of a string into one
// output word and holds it until taken. Depends on gsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsp_format (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           load,
  input  gsp_pkg::parse_state_t               st,
  input  wire logic [gsp_pkg::VALUE_BITS-1:0] w_acc,
  input  wire logic [gsp_pkg::VALUE_BITS-1:0] h_acc,
  input  wire logic [gsp_pkg::VALUE_BITS-1:0] x_acc,
  input  wire logic [gsp_pkg::VALUE_BITS-1:0] y_acc,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic                                out_width_found,
  output logic                                out_height_found,
  output logic                                out_x_found,
  output logic                                out_y_found,
  output logic                                out_x_negative,
  output logic                                out_y_negative,
  output logic      [15:0]                    out_width_value,
  output logic      [15:0]                    out_height_value,
  output logic signed [16:0]                  out_x_value,
  output logic signed [16:0]                  out_y_value
);

  logic        ok;
  logic [3:0]  found;
  logic [1:0]  neg;
  logic        valid_r, valid_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [15:0] w_r, w_nxt, h_r, h_nxt;
  logic [16:0] x_r, x_nxt, y_r, y_nxt;
  logic [16:0] h_full;
  logic [15:0] h_ext;

  always_comb begin
    ok = !st.err && (st.phase inside {gsp_pkg::PH_WNUM, gsp_pkg::PH_HNUM,
                                      gsp_pkg::PH_XNUM, gsp_pkg::PH_YNUM});
    found     = ok ? st.found : 4'b0000;
    neg       = ok ? st.neg : 2'b00;
    flags_nxt = {neg, found};
    w_nxt     = found[0] ? gsp_pkg::unsigned_field(w_acc) : 16'd0;
    h_full    = gsp_pkg::signed_field(h_acc, st.inner[0]);
    h_ext     = h_full[15:0];
    h_nxt     = found[1] ? h_ext : 16'd0;
    x_nxt     = found[2] ? gsp_pkg::signed_field(x_acc, st.neg[0] ^ st.inner[1]) : 17'd0;
    y_nxt     = found[3] ? gsp_pkg::signed_field(y_acc, st.neg[1] ^ st.inner[2]) : 17'd0;
    valid_nxt = load | (valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= flags_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_width_found  = flags_r[0];
  assign out_height_found = flags_r[1];
  assign out_x_found      = flags_r[2];
  assign out_y_found      = flags_r[3];
  assign out_x_negative   = flags_r[4];
  assign out_y_negative   = flags_r[5];
  assign out_width_value  = w_r;
  assign out_height_value = h_r;
  assign out_x_value      = signed'(x_r);
  assign out_y_value      = signed'(y_r);

endmodule
`default_nettype wire

// ===== rtl/geometry_string_parser_core.sv =====
// Geometry string parser top level. An accepted character word is held in the input
// register; a NUL there, once the result register is free, loads it from the parser state.
// Throughput: one character word per cycle unless the input stalls, set by the parser
// step behind the input register. A pending result does not block characters;
// only a NUL waits for the result register. Synchronous active-low reset
// returns the parser to start of string. Depends on gsp_pkg, gsp_parser and gsp_format.
`timescale 1ns / 1ps
`default_nettype none
module geometry_string_parser_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_ch,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_width_found,
  output logic                    out_height_found,
  output logic                    out_x_found,
  output logic                    out_y_found,
  output logic                    out_x_negative,
  output logic                    out_y_negative,
  output logic        [15:0]      out_width_value,
  output logic        [15:0]      out_height_value,
  output logic signed [16:0]      out_x_value,
  output logic signed [16:0]      out_y_value
);

  logic                           ch_valid_r, ch_valid_nxt;
  logic [7:0]                     ch_r;
  logic                           out_free, proc_go, accept, nul_go;
  gsp_pkg::parse_state_t          st;
  logic [gsp_pkg::VALUE_BITS-1:0] w_acc, h_acc, x_acc, y_acc;

  always_comb begin
    out_free     = !out_valid || !out_stall;
    proc_go      = ch_valid_r && ((ch_r != gsp_pkg::CH_NUL) || out_free);
    nul_go       = proc_go && (ch_r == gsp_pkg::CH_NUL);
    in_stall     = ch_valid_r && !proc_go;
    accept       = in_valid && !in_stall;
    ch_valid_nxt = accept | (ch_valid_r & !proc_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_valid_r <= 1'b0;
    end else begin
      ch_valid_r <= ch_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r <= in_ch;
    end
  end

  gsp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (proc_go),
    .ch    (ch_r),
    .st    (st),
    .w_acc (w_acc),
    .h_acc (h_acc),
    .x_acc (x_acc),
    .y_acc (y_acc)
  );

  gsp_format u_format (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (nul_go),
    .st               (st),
    .w_acc            (w_acc),
    .h_acc            (h_acc),
    .x_acc            (x_acc),
    .y_acc            (y_acc),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_width_found  (out_width_found),
    .out_height_found (out_height_found),
    .out_x_found      (out_x_found),
    .out_y_found      (out_y_found),
    .out_x_negative   (out_x_negative),
    .out_y_negative   (out_y_negative),
    .out_width_value  (out_width_value),
    .out_height_value (out_height_value),
    .out_x_value      (out_x_value),
    .out_y_value      (out_y_value)
  );

  a_stall_only_on_nul: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (ch_valid_r && ch_r == gsp_pkg::CH_NUL && out_valid && out_stall))
    else $error("input stalled without a blocked end-of-string word");

  a_x_neg_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_x_negative) |-> out_x_found)
    else $error("x offset negative without x offset found");

  a_y_neg_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_y_negative) |-> out_y_found)
    else $error("y offset negative without y offset found");

  a_result_from_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(nul_go))
    else $error("result word appeared without an end-of-string word");

endmodule
`default_nettype wire
